/* hw/rtl/spe_pkg.sv */
// Shared types and constants for the sliding patch extractor.
package spe_pkg;

    localparam int SIDE_CAP    = 8;
    localparam int SIDE_W      = 4;
    localparam int ELEM_W      = 6;
    localparam int PATCH_W     = 20;
    localparam int SLOT_MAX_W  = 5;
    localparam int COL_MAX_W   = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        REG_PATCH_SIZE   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]  patch_size;
        logic [10:0] image_width;
        logic [10:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_MAX_W-1:0] top_slot;
        logic [COL_MAX_W-1:0]  left;
        logic [SIDE_W-1:0]     side;
        logic [PATCH_W-1:0]    pnum;
    } t_job;

    typedef struct packed {
        logic                  en;
        logic [SLOT_MAX_W-1:0] slot;
        logic [COL_MAX_W-1:0]  col;
        logic [7:0]            data;
    } t_store_wr;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

/* hw/rtl/sliding_patch_extractor.sv */
// Top level of the sliding patch extractor: register port, intake, queue and readout.
// Pixels arrive on the s_axis channel in raster order, one byte per request in
// tdata, with tuser high on the first pixel of a frame. Each pixel that is the
// bottom-right corner of a full square window makes the block send that
// window's P*P bytes on m_axis, row by row, with element index and running patch
// number in tdata and tlast on the final element. P, image width and height sit
// in APB registers at 0x0, 0x4 and 0x8; write them only while the block is idle.
// The request from an accepted pixel passes through the queue, the readout's idle and
// run states, the store read stage and the output register before its first element.
// The readout sends one element per cycle while m_axis is ready, a rate set by the
// single read port of the line store; a patch has P*P elements (at most 64). Up to
// four patch requests wait in the queue; a pixel is taken while requests are pending
// only if it lies further right in the row of the newest request.
// Reset clears the position counters, the patch number, the queue and the
// output; the registers return to P=8 and a 16 by 16 image. Line store contents
// are not cleared and need no clearing pass. A stalled m_axis holds its element;
// the readout and then the queue back up, and s_axis tready drops.
module sliding_patch_extractor #(
    parameter int MAX_PATCH = 16,
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] pixel
    input  logic        s_axis_tuser,  // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [7:0] value, [15:8] element_index, [35:16] patch_index
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spe_pkg::*;

    t_cfg               r_cfg;
    t_reg_idx           reg_idx;
    logic               cfg_wr;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    logic               back_busy;
    t_job               push_job;
    t_job               head_job;
    t_store_wr          store_wr;
    logic [7:0]         out_value;
    logic [7:0]         out_elem;
    logic [PATCH_W-1:0] out_pnum;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.patch_size   <= 5'd8;
            r_cfg.image_width  <= 11'd16;
            r_cfg.image_height <= 11'd16;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PATCH_SIZE:   r_cfg.patch_size   <= pwdata[4:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATCH_SIZE:   prdata = 32'(r_cfg.patch_size);
            REG_IMAGE_WIDTH:  prdata = 32'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_cfg.image_height);
            default:          prdata = '0;
        endcase
    end

    spe_front #(
        .MAX_PATCH(MAX_PATCH),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .i_pixel      (s_axis_tdata),
        .i_frame_start(s_axis_tuser),
        .o_ready      (s_axis_tready),
        .i_q_full     (q_full),
        .i_pending    (!q_empty || back_busy),
        .o_push       (q_push),
        .o_job        (push_job),
        .o_wr         (store_wr)
    );

    spe_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .i_pop  (q_pop),
        .o_head (head_job),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    spe_back #(
        .MAX_PATCH(MAX_PATCH),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_q_empty(q_empty),
        .i_q_head (head_job),
        .o_pop    (q_pop),
        .o_busy   (back_busy),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (out_value),
        .o_elem   (out_elem),
        .o_pnum   (out_pnum),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_pnum, out_elem, out_value};

endmodule

/* hw/rtl/spe_front.sv */
// Pixel intake: position tracking, line store write and patch request issue.
module spe_front #(
    parameter int MAX_PATCH = 16,
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spe_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_pixel,
    input  logic              i_frame_start,
    output logic              o_ready,
    input  logic              i_q_full,
    input  logic              i_pending,
    output logic              o_push,
    output spe_pkg::t_job     o_job,
    output spe_pkg::t_store_wr o_wr
);
    import spe_pkg::*;

    localparam int LIM = (MAX_PATCH < SIDE_CAP) ? MAX_PATCH : SIDE_CAP;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SW  = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;

    logic [9:0]         r_row;
    logic [CW-1:0]      r_col;
    logic [SW-1:0]      r_slot;
    logic [PATCH_W-1:0] r_pcnt;
    logic [SW-1:0]      r_last_slot;
    logic [CW-1:0]      r_last_col;

    logic [9:0]         n_row;
    logic [CW-1:0]      n_col;
    logic [SW-1:0]      n_slot;

    logic [SIDE_W-1:0]  side_p;
    logic [SIDE_W-1:0]  pm1;
    logic [12:0]        iw_ext;
    logic [CW:0]        wid;
    logic [10:0]        hgt;
    logic [10:0]        row_a;
    logic [CW:0]        col_a;
    logic [SW-1:0]      slot_a;
    logic [9:0]         row_c;
    logic [CW-1:0]      col_c;
    logic [SW-1:0]      slot_c;
    logic [10:0]        row_nx;
    logic [CW:0]        col_nx;
    logic [5:0]         top6;
    logic               has_job;
    logic               safe;
    logic               acc;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(MAX_PATCH - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb begin
        if (i_cfg.patch_size == '0) begin
            side_p = SIDE_W'(1);
        end else if (i_cfg.patch_size > 5'(LIM)) begin
            side_p = SIDE_W'(LIM);
        end else begin
            side_p = SIDE_W'(i_cfg.patch_size);
        end
        pm1 = side_p - 1'b1;

        iw_ext = 13'(i_cfg.image_width);
        if (i_cfg.image_width == '0) begin
            wid = (CW+1)'(1);
        end else if (iw_ext > 13'(MAX_WIDTH)) begin
            wid = (CW+1)'(MAX_WIDTH);
        end else begin
            wid = (CW+1)'(i_cfg.image_width);
        end

        if (i_cfg.image_height == '0) begin
            hgt = 11'd1;
        end else if (i_cfg.image_height > 11'd1024) begin
            hgt = 11'd1024;
        end else begin
            hgt = i_cfg.image_height;
        end

        row_a  = i_frame_start ? '0 : {1'b0, r_row};
        col_a  = i_frame_start ? '0 : {1'b0, r_col};
        slot_a = i_frame_start ? '0 : r_slot;
        if (col_a >= wid) begin
            col_a  = '0;
            row_a  = row_a + 1'b1;
            slot_a = slot_inc(slot_a);
        end
        if (row_a >= hgt) begin
            row_a  = '0;
            slot_a = '0;
        end
        row_c  = row_a[9:0];
        col_c  = col_a[CW-1:0];
        slot_c = slot_a;

        has_job = ({1'b0, row_c} >= 11'(pm1)) && (col_a >= (CW+1)'(pm1));
        if (6'(slot_c) >= 6'(pm1)) begin
            top6 = 6'(slot_c) - 6'(pm1);
        end else begin
            top6 = 6'(slot_c) + 6'(MAX_PATCH) - 6'(pm1);
        end

        col_nx = {1'b0, col_c} + 1'b1;
        row_nx = {1'b0, row_c} + 1'b1;
        if (col_nx >= wid) begin
            n_col = '0;
            if (row_nx >= hgt) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = row_nx[9:0];
                n_slot = slot_inc(slot_c);
            end
        end else begin
            n_col  = col_nx[CW-1:0];
            n_row  = row_c;
            n_slot = slot_c;
        end

        safe    = (slot_c == r_last_slot) && (col_c > r_last_col);
        o_ready = !i_q_full && (!i_pending || safe);
        acc     = i_valid && o_ready;
        o_push  = acc && has_job;

        o_job.top_slot = top6[SLOT_MAX_W-1:0];
        o_job.left     = COL_MAX_W'(col_c - CW'(pm1));
        o_job.side     = side_p;
        o_job.pnum     = r_pcnt;

        o_wr.en   = acc;
        o_wr.slot = SLOT_MAX_W'(slot_c);
        o_wr.col  = COL_MAX_W'(col_c);
        o_wr.data = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_slot      <= '0;
            r_pcnt      <= '0;
            r_last_slot <= '0;
            r_last_col  <= '0;
        end else if (acc) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
            if (has_job) begin
                r_pcnt      <= r_pcnt + 1'b1;
                r_last_slot <= slot_c;
                r_last_col  <= col_c;
            end
        end
    end

endmodule

/* hw/rtl/spe_queue.sv */
// Short request queue between the intake and the patch readout.
module spe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spe_pkg::t_job i_job,
    input  logic          i_pop,
    output spe_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import spe_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* hw/rtl/spe_back.sv */
// Line store and patch readout: walks each requested window, one element a cycle unless stalled.
module spe_back #(
    parameter int MAX_PATCH = 16,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spe_pkg::t_store_wr         i_wr,
    input  logic                       i_q_empty,
    input  spe_pkg::t_job              i_q_head,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_value,
    output logic [7:0]                 o_elem,
    output logic [spe_pkg::PATCH_W-1:0] o_pnum,
    output logic                       o_last
);
    import spe_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int SW     = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
    localparam int DEPTH  = MAX_PATCH * (2 ** CW);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] r_store [DEPTH];

    t_back_state        r_state, n_state;
    logic [SW-1:0]      r_slot, n_slot;
    logic [CW-1:0]      r_left, n_left;
    logic [2:0]         r_u, n_u;
    logic [2:0]         r_v, n_v;
    logic [SIDE_W-1:0]  r_side, n_side;
    logic [PATCH_W-1:0] r_pnum, n_pnum;
    logic [ELEM_W-1:0]  r_elem, n_elem;

    logic [7:0]         r_rd_data;
    logic               r_s1_valid;
    logic [ELEM_W-1:0]  r_s1_elem;
    logic [PATCH_W-1:0] r_s1_pnum;
    logic               r_s1_last;

    logic               r_o_valid;
    logic [7:0]         r_o_value;
    logic [ELEM_W-1:0]  r_o_elem;
    logic [PATCH_W-1:0] r_o_pnum;
    logic               r_o_last;

    logic               s1_move;
    logic               s1_free;
    logic               issue;
    logic               v_end;
    logic               u_end;
    logic               last_el;
    logic [CW-1:0]      rd_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    always_comb begin
        s1_move = !r_o_valid || i_ready;
        s1_free = !r_s1_valid || s1_move;
        issue   = (r_state == BK_RUN) && s1_free;
        v_end   = ({1'b0, r_v} == r_side - 1'b1);
        u_end   = ({1'b0, r_u} == r_side - 1'b1);
        last_el = v_end && u_end;
        rd_col  = r_left + CW'(r_v);
        rd_addr = ADDR_W'({r_slot, rd_col});
        wr_addr = ADDR_W'({i_wr.slot[SW-1:0], i_wr.col[CW-1:0]});
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_left  = r_left;
        n_u     = r_u;
        n_v     = r_v;
        n_side  = r_side;
        n_pnum  = r_pnum;
        n_elem  = r_elem;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_RUN;
                    n_slot  = i_q_head.top_slot[SW-1:0];
                    n_left  = i_q_head.left[CW-1:0];
                    n_side  = i_q_head.side;
                    n_pnum  = i_q_head.pnum;
                    n_u     = '0;
                    n_v     = '0;
                    n_elem  = '0;
                end
            end
            BK_RUN: begin
                if (issue) begin
                    if (last_el) begin
                        if (!i_q_empty) begin
                            o_pop  = 1'b1;
                            n_slot = i_q_head.top_slot[SW-1:0];
                            n_left = i_q_head.left[CW-1:0];
                            n_side = i_q_head.side;
                            n_pnum = i_q_head.pnum;
                            n_u    = '0;
                            n_v    = '0;
                            n_elem = '0;
                        end else begin
                            n_state = BK_IDLE;
                        end
                    end else begin
                        n_elem = r_elem + 1'b1;
                        if (v_end) begin
                            n_v    = '0;
                            n_u    = r_u + 1'b1;
                            n_slot = (r_slot == SW'(MAX_PATCH - 1)) ? '0 : r_slot + 1'b1;
                        end else begin
                            n_v = r_v + 1'b1;
                        end
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_left <= n_left;
        r_u    <= n_u;
        r_v    <= n_v;
        r_side <= n_side;
        r_pnum <= n_pnum;
        r_elem <= n_elem;
        if (issue) begin
            r_s1_elem <= r_elem;
            r_s1_pnum <= r_pnum;
            r_s1_last <= last_el;
        end
        if (r_s1_valid && s1_move) begin
            r_o_value <= r_rd_data;
            r_o_elem  <= r_s1_elem;
            r_o_pnum  <= r_s1_pnum;
            r_o_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign o_busy  = (r_state == BK_RUN);
    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_elem  = 8'(r_o_elem);
    assign o_pnum  = r_o_pnum;
    assign o_last  = r_o_last;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("request taken from an empty queue");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_ready) |-> !issue)
        else $error("store read issued while the read stage is blocked");

    a_col_in_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN) |-> (({1'b0, r_v} < r_side) && ({1'b0, r_u} < r_side)))
        else $error("window walk outside the patch side");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == BK_IDLE && !r_o_valid))
        else $error("readout active right after reset");

endmodule
